/* design/ipid_pkg.sv */
// Shared types, codes and saturating helpers for the incremental PID controller.
`timescale 1ns / 1ps
package ipid_pkg;

    localparam int DATA_W = 32;
    localparam int DT_W   = 24;
    localparam int DIV_W  = DATA_W + DT_W;
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Operation codes carried on tuser.
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_ERROR  = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;
    localparam logic [1:0] OP_PRESET = 2'd3;

    // Register indexes.
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_KP    = 3'd1;
    localparam logic [2:0] REG_KI    = 3'd2;
    localparam logic [2:0] REG_KD    = 3'd3;
    localparam logic [2:0] REG_OLIM  = 3'd4;
    localparam logic [2:0] REG_DLIM  = 3'd5;
    localparam logic [2:0] REG_DBS   = 3'd6;
    localparam logic [2:0] REG_RAMP  = 3'd7;

    // Bits of the mode register.
    localparam int FLAG_OUT_CLAMP = 0;
    localparam int FLAG_DLT_CLAMP = 1;
    localparam int FLAG_COND_INT  = 2;
    localparam int FLAG_REVERSE   = 3;
    localparam int FLAG_D_ON_ERR  = 4;

    localparam logic [63:0] LIMIT_RESET = 64'h7FFF_FFFF_8000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        logic signed [65:0] hi_lim;
        logic signed [65:0] lo_lim;
        logic signed [31:0] r;
        hi_lim = 66'sd2147483647;
        lo_lim = -66'sd2147483648;
        if (v > hi_lim)
            r = 32'sh7FFF_FFFF;
        else if (v < lo_lim)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] negsat(input logic signed [31:0] v);
        return sat66(-66'(v));
    endfunction

    function automatic logic [32:0] abs33(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        return (w < 0) ? 33'(-w) : 33'(w);
    endfunction

    function automatic logic signed [31:0] lim_lo(input logic [63:0] r);
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = r[63:32];
        mn = r[31:0];
        return (mx < mn) ? mx : mn;
    endfunction

    function automatic logic signed [31:0] lim_hi(input logic [63:0] r);
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = r[63:32];
        mn = r[31:0];
        return (mx < mn) ? mn : mx;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                   input logic [63:0] r);
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] x;
        lo = lim_lo(r);
        hi = lim_hi(r);
        x = v;
        if (v < lo)
            x = lo;
        else if (hi < v)
            x = hi;
        return x;
    endfunction

    // Saturates a sign and a magnitude from the divider to 32 bits.
    function automatic logic signed [31:0] sat_quot(input logic neg,
                                                    input logic [DIV_W-1:0] mag);
        logic signed [31:0] r;
        if (!neg)
            r = (mag > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : mag[31:0];
        else
            r = (mag > DIV_W'(32'h8000_0000)) ? 32'sh8000_0000 : -mag[31:0];
        return r;
    endfunction

endpackage

/* design/incremental_pid_controller_unit.sv */
// Top level of the incremental PID controller: sequencer, state and register file.
`timescale 1ns / 1ps
// Incremental (velocity-form) PID controller in Q16.16 fixed point.
// Input words arrive on the s_ stream; tuser carries the operation (update from
// target and feedback, update from a given error, reset, reset to a target and
// feedback) and tdata the operands. Every input word yields exactly one output
// word on the m_ stream: the drive value after that word.
// The user is to write the coefficients, limits, deadband and ramp rate over
// the APB port while the block is idle; the block itself does not enforce
// this. Every register lies at byte address 8*index. One input word is
// handled at a time. s_tready is high only while the sequencer is idle. An
// update walks through one shared multiplier, five products in turn, and,
// when a derivative term applies, a 56-step restoring divider by dt. A
// ramped setpoint adds its own step before the error step. Resets and
// updates with zero dt skip the arithmetic and go straight to the output
// step. The result waits in an output register; a stalled receiver holds
// the sequencer in its final step only if the previous word has not been
// taken. Reset clears every register to its documented value and the
// controller history to zero; the block is ready as soon as reset ends.
module incremental_pid_controller_unit
(
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // target, feedback, error_in, dt, preset_output
    input  logic [1:0]   s_tuser,   // operation
    // Output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata    // output_res
);
    import ipid_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_RAMPT  = 4'd2;
    localparam logic [3:0] S_ERR    = 4'd3;
    localparam logic [3:0] S_PMUL   = 4'd4;
    localparam logic [3:0] S_PTAKE  = 4'd5;
    localparam logic [3:0] S_ITAKE  = 4'd6;
    localparam logic [3:0] S_I2     = 4'd7;
    localparam logic [3:0] S_I2TAKE = 4'd8;
    localparam logic [3:0] S_DMUL   = 4'd9;
    localparam logic [3:0] S_DTAKE  = 4'd10;
    localparam logic [3:0] S_DWAIT  = 4'd11;
    localparam logic [3:0] S_SUM    = 4'd12;
    localparam logic [3:0] S_DRIVE  = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    // Configuration registers.
    logic [4:0]         mode_reg;
    logic signed [31:0] gain_p_reg;
    logic signed [31:0] gain_i_reg;
    logic signed [31:0] gain_d_reg;
    logic [63:0]        olim_reg;
    logic [63:0]        dlim_reg;
    logic [63:0]        dbs_reg;
    logic [30:0]        ramp_reg;

    // Captured input word.
    logic [1:0]         op_reg;
    logic signed [31:0] tgt_reg;
    logic signed [31:0] fb_reg;
    logic signed [31:0] ein_reg;
    logic [DT_W-1:0]    dt_reg;
    logic signed [31:0] preset_reg;

    // Controller state.
    logic signed [31:0] drive_reg;
    logic signed [31:0] ramped_reg;
    logic signed [31:0] el_reg;
    logic signed [31:0] ebl_reg;
    logic signed [31:0] fl_reg;
    logic signed [31:0] fbl_reg;
    logic               started_reg;
    logic               sp_started_reg;
    logic               fb_started_reg;

    // Working registers of one update.
    logic [3:0]         state_reg;
    logic signed [31:0] err_reg;
    logic               fbv_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] i_reg;
    logic signed [31:0] d_reg;
    logic               dsel_fb_reg;
    logic               dneg_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] product;
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DIV_W-1:0]         quotient;
    div_stat_t                div_st;

    logic               cfg_wr;
    logic               accept;
    logic               load_out;
    logic signed [31:0] dir_src;
    logic signed [31:0] dir_e;
    logic signed [31:0] db_e;
    logic signed [31:0] db_val;
    logic signed [31:0] sep_val;
    logic signed [31:0] limited_preset;
    logic signed [31:0] m_val;
    logic [32:0]        m_mag;
    logic signed [31:0] q_val;
    logic signed [31:0] dd_fb;
    logic signed [31:0] dd_err;
    logic signed [31:0] dp_diff;
    logic signed [31:0] i_eff;
    logic signed [31:0] total_raw;
    logic signed [31:0] drive_new;
    logic [30:0]        ramp_step;
    logic signed [32:0] ramp_delta;
    logic [32:0]        ramp_dmag;
    logic signed [31:0] ramp_new;

    assign cfg_wr   = psel & penable & pwrite & pready;
    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        unique case (paddr[5:3])
            REG_MODE: prdata = 64'(mode_reg);
            REG_KP:   prdata = 64'(unsigned'(gain_p_reg));
            REG_KI:   prdata = 64'(unsigned'(gain_i_reg));
            REG_KD:   prdata = 64'(unsigned'(gain_d_reg));
            REG_OLIM: prdata = olim_reg;
            REG_DLIM: prdata = dlim_reg;
            REG_DBS:  prdata = dbs_reg;
            REG_RAMP: prdata = 64'(ramp_reg);
            default:  prdata = '0;
        endcase
    end

    // Error with direction and deadband; the reset-to-target path uses the raw
    // target, an update uses the ramped setpoint.
    always_comb
    begin
        dir_src = (state_reg == S_DISP) ? tgt_reg : ramped_reg;
        dir_e   = sat66(66'(dir_src) - 66'(fb_reg));
        if (mode_reg[FLAG_REVERSE])
            dir_e = negsat(dir_e);
        db_val  = dbs_reg[31:0];
        sep_val = dbs_reg[63:32];
        db_e    = (state_reg == S_ERR && op_reg == OP_ERROR) ? ein_reg : dir_e;
        if (db_val > 0 && abs33(db_e) <= 33'(db_val))
            db_e = '0;
    end

    assign limited_preset = mode_reg[FLAG_OUT_CLAMP] ? clamp32(preset_reg, olim_reg)
                                                     : preset_reg;

    // Setpoint ramp.
    always_comb
    begin
        ramp_step  = product[54:24];
        ramp_delta = 33'(tgt_reg) - 33'(ramped_reg);
        ramp_dmag  = (ramp_delta < 0) ? 33'(-ramp_delta) : 33'(ramp_delta);
        if (ramp_dmag <= 33'(ramp_step))
            ramp_new = tgt_reg;
        else if (ramp_delta > 0)
            ramp_new = sat66(66'(ramped_reg) + 66'(ramp_step));
        else
            ramp_new = sat66(66'(ramped_reg) - 66'(ramp_step));
    end

    assign dp_diff = sat66(66'(err_reg) - 66'(el_reg));
    assign dd_fb   = sat66(66'(fb_reg) - 66'(fl_reg) - 66'(fl_reg) + 66'(fbl_reg));
    assign dd_err  = sat66(66'(err_reg) - 66'(el_reg) - 66'(el_reg) + 66'(ebl_reg));
    assign m_val   = sat66(product >>> 16);
    assign q_val   = sat_quot(dneg_reg, quotient);

    // Integral separation and conditional integration, then the clamped step and new drive.
    always_comb
    begin
        i_eff = i_reg;
        if (sep_val > 0 && 33'(sep_val) < abs33(err_reg))
            i_eff = '0;
        if (mode_reg[FLAG_COND_INT] && mode_reg[FLAG_OUT_CLAMP])
        begin
            if ((lim_hi(olim_reg) <= drive_reg && i_reg > 0) ||
                (drive_reg <= lim_lo(olim_reg) && i_reg < 0))
                i_eff = '0;
        end
        total_raw = sat66(66'(p_reg) + 66'(i_eff) + 66'(d_reg));
        if (mode_reg[FLAG_DLT_CLAMP])
            total_raw = clamp32(total_raw, dlim_reg);
        drive_new = sat66(66'(drive_reg) + 66'(p_reg));
        if (mode_reg[FLAG_OUT_CLAMP])
            drive_new = clamp32(drive_new, olim_reg);
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DISP:
            begin
                mul_a = MUL_W'(ramp_reg);
                mul_b = MUL_W'(dt_reg);
            end
            S_PMUL:
            begin
                mul_a = MUL_W'(gain_p_reg);
                mul_b = MUL_W'(dp_diff);
            end
            S_PTAKE:
            begin
                mul_a = MUL_W'(gain_i_reg);
                mul_b = MUL_W'(err_reg);
            end
            S_I2:
            begin
                mul_a = MUL_W'(i_reg);
                mul_b = MUL_W'(dt_reg);
            end
            S_DMUL:
            begin
                mul_a = MUL_W'(gain_d_reg);
                mul_b = (fbv_reg && !mode_reg[FLAG_D_ON_ERR]) ? MUL_W'(dd_fb)
                                                              : MUL_W'(dd_err);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign m_mag        = abs33(m_val);
    assign div_start    = (state_reg == S_DTAKE);
    assign div_dividend = {m_mag[31:0], DT_W'(0)};

    ipid_mul u_mul
    (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    ipid_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dt_reg),
        .status   (div_st),
        .quotient (quotient)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            olim_reg   <= LIMIT_RESET;
            dlim_reg   <= LIMIT_RESET;
            dbs_reg    <= '0;
            ramp_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                REG_MODE: mode_reg   <= pwdata[4:0];
                REG_KP:   gain_p_reg <= pwdata[31:0];
                REG_KI:   gain_i_reg <= pwdata[31:0];
                REG_KD:   gain_d_reg <= pwdata[31:0];
                REG_OLIM: olim_reg   <= pwdata;
                REG_DLIM: dlim_reg   <= pwdata;
                REG_DBS:  dbs_reg    <= pwdata;
                REG_RAMP: ramp_reg   <= pwdata[30:0];
                default:  mode_reg   <= mode_reg;
            endcase
        end
    end

    // Input capture and working values.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tuser;
            tgt_reg    <= s_tdata[31:0];
            fb_reg     <= s_tdata[63:32];
            ein_reg    <= s_tdata[95:64];
            dt_reg     <= s_tdata[119:96];
            preset_reg <= s_tdata[151:120];
        end
        unique case (state_reg)
            S_ERR:
            begin
                err_reg <= db_e;
                fbv_reg <= (op_reg == OP_UPDATE);
            end
            S_PTAKE:  p_reg <= m_val;
            S_ITAKE:  i_reg <= m_val;
            S_I2TAKE: i_reg <= sat66(product >>> 24);
            S_DMUL:
            begin
                d_reg       <= '0;
                dsel_fb_reg <= fbv_reg && !mode_reg[FLAG_D_ON_ERR];
            end
            S_DTAKE:  dneg_reg <= (m_val < 0);
            S_DWAIT:
            begin
                if (dsel_fb_reg && !mode_reg[FLAG_REVERSE])
                    d_reg <= negsat(q_val);
                else
                    d_reg <= q_val;
            end
            S_SUM:    p_reg <= total_raw;
            default:  p_reg <= p_reg;
        endcase
    end

    // Sequencer and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            drive_reg      <= '0;
            ramped_reg     <= '0;
            el_reg         <= '0;
            ebl_reg        <= '0;
            fl_reg         <= '0;
            fbl_reg        <= '0;
            started_reg    <= 1'b0;
            sp_started_reg <= 1'b0;
            fb_started_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_DISP;
                end
                S_DISP:
                begin
                    priority if (op_reg == OP_RESET)
                    begin
                        drive_reg      <= limited_preset;
                        ramped_reg     <= '0;
                        el_reg         <= '0;
                        ebl_reg        <= '0;
                        fl_reg         <= '0;
                        fbl_reg        <= '0;
                        started_reg    <= 1'b0;
                        sp_started_reg <= 1'b0;
                        fb_started_reg <= 1'b0;
                        state_reg      <= S_OUT;
                    end
                    else if (op_reg == OP_PRESET)
                    begin
                        drive_reg      <= limited_preset;
                        ramped_reg     <= tgt_reg;
                        el_reg         <= db_e;
                        ebl_reg        <= db_e;
                        fl_reg         <= fb_reg;
                        fbl_reg        <= fb_reg;
                        started_reg    <= 1'b1;
                        sp_started_reg <= 1'b1;
                        fb_started_reg <= 1'b1;
                        state_reg      <= S_OUT;
                    end
                    else if (dt_reg == '0)
                        state_reg <= S_OUT;
                    else if (op_reg == OP_ERROR)
                    begin
                        sp_started_reg <= 1'b0;
                        fb_started_reg <= 1'b0;
                        state_reg      <= S_ERR;
                    end
                    else if (sp_started_reg && ramp_reg != '0)
                        state_reg <= S_RAMPT;
                    else
                    begin
                        ramped_reg     <= tgt_reg;
                        sp_started_reg <= 1'b1;
                        state_reg      <= S_ERR;
                    end
                end
                S_RAMPT:
                begin
                    ramped_reg <= ramp_new;
                    state_reg  <= S_ERR;
                end
                S_ERR:    state_reg <= S_PMUL;
                S_PMUL:   state_reg <= S_PTAKE;
                S_PTAKE:  state_reg <= S_ITAKE;
                S_ITAKE:  state_reg <= S_I2;
                S_I2:     state_reg <= S_I2TAKE;
                S_I2TAKE: state_reg <= S_DMUL;
                S_DMUL:
                begin
                    // No derivative on the first update, nor on the first
                    // valid feedback when it acts on feedback.
                    if (!started_reg ||
                        (fbv_reg && !mode_reg[FLAG_D_ON_ERR] && !fb_started_reg))
                        state_reg <= S_SUM;
                    else
                        state_reg <= S_DTAKE;
                end
                S_DTAKE:  state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_st.done)
                        state_reg <= S_SUM;
                end
                S_SUM:    state_reg <= S_DRIVE;
                S_DRIVE:
                begin
                    // p_reg now holds the clamped step.
                    drive_reg <= drive_new;
                    if (!started_reg)
                    begin
                        ebl_reg        <= err_reg;
                        el_reg         <= err_reg;
                        fbl_reg        <= fbv_reg ? fb_reg : '0;
                        fl_reg         <= fbv_reg ? fb_reg : '0;
                        started_reg    <= 1'b1;
                        fb_started_reg <= fbv_reg;
                    end
                    else
                    begin
                        ebl_reg <= el_reg;
                        el_reg  <= err_reg;
                        if (fbv_reg)
                        begin
                            fbl_reg        <= fb_started_reg ? fl_reg : fb_reg;
                            fl_reg         <= fb_reg;
                            fb_started_reg <= 1'b1;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (load_out)
                    begin
                        out_data_reg <= drive_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // An accepted word leaves the sequencer busy, with s_tready low, in the cycle after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken while the sequencer is busy");

    // The divider only runs while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_st.busy |-> state_reg == S_DWAIT)
        else $error("divider running outside its wait step");

    // Feedback history is never marked valid without a started controller.
    assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> !fb_started_reg)
        else $error("feedback history valid before the first update");

    // A result is only loaded after an input word has been worked through.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result loaded outside the output step");

endmodule

/* design/ipid_mul.sv */
// Shared signed 33 by 33 bit multiplier with a registered product.
`timescale 1ns / 1ps
module ipid_mul
(
    input  logic                                    clk,
    input  logic signed [ipid_pkg::MUL_W-1:0]       op_a,
    input  logic signed [ipid_pkg::MUL_W-1:0]       op_b,
    output logic signed [ipid_pkg::PROD_W-1:0]      product
);
    import ipid_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign product = prod_reg;

endmodule

/* design/ipid_div.sv */
// Restoring divider, one quotient bit per cycle, for the derivative term.
`timescale 1ns / 1ps
module ipid_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ipid_pkg::DIV_W-1:0]        dividend,
    input  logic [ipid_pkg::DT_W-1:0]         divisor,
    output ipid_pkg::div_stat_t               status,
    output logic [ipid_pkg::DIV_W-1:0]        quotient
);
    import ipid_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] num_reg;
    logic [DT_W-1:0]  rem_reg;
    logic [DT_W:0]    trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DT_W'(trial - {1'b0, divisor}) : trial[DT_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = num_reg;

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the incremental PID controller unit.
`timescale 1ns / 1ps
module tb_top;
    import ipid_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE_CYCLES = 100;

    // One input word as the block sees it, with the fields already typed.
    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] target;
        logic signed [31:0] feedback;
        logic signed [31:0] error_in;
        logic [23:0]        dt;
        logic signed [31:0] preset;
    } pid_word_t;

    // Tracks the controller's registers and history, and holds the drive values
    // that are still owed by the block, oldest first.
    class drive_predictor;
        logic [4:0]  mode;
        logic [31:0] kp, ki, kd;
        logic [63:0] olim, dlim, dbs;
        logic [30:0] ramp;
        int drive, ramped, e1, e2, fb1, fb2;
        bit started, sp_started, fb_started;
        int drive_expected[$];
        int mismatches;

        function new();
            mode = 0; kp = 0; ki = 0; kd = 0;
            olim = LIMIT_RESET; dlim = LIMIT_RESET; dbs = 0; ramp = 0;
            drive = 0;
            mismatches = 0;
            forget();
        endfunction

        function void forget();
            ramped = 0; e1 = 0; e2 = 0; fb1 = 0; fb2 = 0;
            started = 0; sp_started = 0; fb_started = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                REG_MODE: mode = v[4:0];
                REG_KP:   kp = v[31:0];
                REG_KI:   ki = v[31:0];
                REG_KD:   kd = v[31:0];
                REG_OLIM: olim = v;
                REG_DLIM: dlim = v;
                REG_DBS:  dbs = v;
                default:  ramp = v[30:0];
            endcase
        endfunction

        function int sat(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return int'(v);
        endfunction

        // Q16.16 product, rounded toward minus infinity by the arithmetic shift.
        function int qmul(longint a, longint b);
            return sat((a * b) >>> 16);
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // Limits with the two halves swapped if they were written the wrong way round.
        function void bounds(logic [63:0] r, output longint lo, output longint hi);
            longint a, b;
            a = longint'(int'(r[63:32]));
            b = longint'(int'(r[31:0]));
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
        endfunction

        function int out_limit(longint v);
            longint lo, hi;
            if (mode[FLAG_OUT_CLAMP]) begin
                bounds(olim, lo, hi);
                if (v < lo)
                    v = lo;
                else if (hi < v)
                    v = hi;
            end
            return sat(v);
        endfunction

        function int dead(int e);
            longint db;
            db = longint'(int'(dbs[31:0]));
            if (db > 0 && mag(e) <= db)
                return 0;
            return e;
        endfunction

        function int steer(longint diff);
            int e;
            e = sat(diff);
            if (mode[FLAG_REVERSE])
                e = sat(-longint'(e));
            return e;
        endfunction

        function void advance(int err, int fb, longint dt, bit fb_ok);
            bit first, first_fb, integ;
            longint sep, lo, hi, m, q;
            int p, i, d, total;
            first = !started;
            first_fb = !fb_started;
            integ = 1;
            d = 0;
            sep = longint'(int'(dbs[63:32]));
            err = dead(err);
            p = qmul(int'(kp), sat(longint'(err) - e1));
            i = sat((longint'(qmul(int'(ki), err)) * dt) >>> 24);
            if (sep > 0 && sep < mag(err))
                integ = 0;
            if (mode[FLAG_COND_INT] && mode[FLAG_OUT_CLAMP]) begin
                bounds(olim, lo, hi);
                if ((hi <= drive && i > 0) || (drive <= lo && i < 0))
                    integ = 0;
            end
            if (!integ)
                i = 0;
            if (!first) begin
                if (fb_ok && !mode[FLAG_D_ON_ERR]) begin
                    if (!first_fb) begin
                        m = qmul(int'(kd), sat(longint'(fb) - 2 * longint'(fb1) + fb2));
                        q = sat((m * 64'sd16777216) / dt);
                        d = mode[FLAG_REVERSE] ? int'(q) : sat(-q);
                    end
                end
                else begin
                    m = qmul(int'(kd), sat(longint'(err) - 2 * longint'(e1) + e2));
                    d = sat((m * 64'sd16777216) / dt);
                end
            end
            total = sat(longint'(p) + i + d);
            if (mode[FLAG_DLT_CLAMP]) begin
                bounds(dlim, lo, hi);
                if (total < lo)
                    total = int'(lo);
                else if (hi < total)
                    total = int'(hi);
            end
            drive = out_limit(longint'(drive) + total);
            if (first) begin
                e2 = err; e1 = err; fb2 = fb; fb1 = fb;
                started = 1;
                fb_started = fb_ok;
            end
            else begin
                e2 = e1;
                e1 = err;
                if (fb_ok) begin
                    fb2 = first_fb ? fb : fb1;
                    fb1 = fb;
                    fb_started = 1;
                end
            end
        endfunction

        function int slew(int tgt, longint dt);
            longint stp, delta;
            if (!sp_started || ramp == 0) begin
                ramped = tgt;
                sp_started = 1;
                return tgt;
            end
            stp = (longint'(ramp) * dt) >>> 24;
            delta = longint'(tgt) - ramped;
            if (mag(delta) <= stp)
                ramped = tgt;
            else if (delta > 0)
                ramped = sat(longint'(ramped) + stp);
            else
                ramped = sat(longint'(ramped) - stp);
            return ramped;
        endfunction

        function void note_word(pid_word_t w);
            longint dt;
            int e;
            dt = longint'(w.dt);
            case (w.op)
                OP_UPDATE: begin
                    if (dt != 0)
                        advance(steer(longint'(slew(w.target, dt)) - w.feedback),
                                w.feedback, dt, 1);
                end
                OP_ERROR: begin
                    if (dt != 0) begin
                        sp_started = 0;
                        fb_started = 0;
                        advance(w.error_in, 0, dt, 0);
                    end
                end
                OP_RESET: begin
                    drive = out_limit(w.preset);
                    forget();
                end
                default: begin
                    e = dead(steer(longint'(w.target) - w.feedback));
                    drive = out_limit(w.preset);
                    ramped = w.target;
                    e1 = e; e2 = e; fb1 = w.feedback; fb2 = w.feedback;
                    started = 1; sp_started = 1; fb_started = 1;
                end
            endcase
            drive_expected.push_back(drive);
        endfunction

        function void check_word(logic [31:0] got);
            int want;
            if (drive_expected.size() == 0) begin
                $error("output_res: no word expected, got %h", got);
                mismatches++;
                return;
            end
            want = drive_expected.pop_front();
            if (got !== want) begin
                $error("output_res: expected %h, got %h", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         psel, penable, pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;

    drive_predictor pred;
    int send_idle_pct;
    int recv_stall_pct;
    int recv_hold = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int cycles = 0;

    incremental_pid_controller_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // The receiver either sits out a long hold, counted down here, or stalls
    // at random according to the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            recv_hold <= 600;
            m_tready <= 1'b0;
        end
        else if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every word taken from the output stream is checked against the oldest
    // expected drive value.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pred.check_word(m_tdata);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Register write: a setup phase, then an access phase at whose end it lands.
    task automatic reg_write(logic [2:0] idx, logic [63:0] v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pred.set_reg(idx, v);
    endtask

    // Waits until the block has handed over everything it owes.
    task automatic drain();
        while (pred.drive_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offers one word, after a random gap where the phase asks for idling.
    // s_tvalid is only lowered at the start of a gap, so it never takes two
    // updates in one step.
    task automatic send_word(pid_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.op;
        s_tdata <= {w.preset, w.dt, w.error_in, w.feedback, w.target};
        do
            @(posedge clk);
        while (!s_tready);
        pred.note_word(w);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly values of moderate size so that the loop does not sit in saturation,
    // with full-range words and the extremes mixed in.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [23:0] pick_dt();
        case ($urandom_range(9))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return $urandom();
            3: return $urandom_range(1, 16);
            default: return $urandom_range(24'h01_0000, 24'h40_0000);
        endcase
    endfunction

    // Well-formed traffic is mostly closed-loop updates; resets are rarer.
    function automatic pid_word_t pick_word();
        pid_word_t w;
        int r;
        r = $urandom_range(99);
        w.op = (r < 60) ? OP_UPDATE : (r < 80) ? OP_ERROR : (r < 88) ? OP_RESET : OP_PRESET;
        w.target = pick_value();
        w.feedback = pick_value();
        w.error_in = pick_value();
        w.dt = pick_dt();
        w.preset = pick_value();
        return w;
    endfunction

    function automatic pid_word_t make_word(logic [1:0] op, logic [31:0] tg, logic [31:0] fb,
                                            logic [31:0] er, logic [23:0] dt,
                                            logic [31:0] pre);
        pid_word_t w;
        w.op = op; w.target = tg; w.feedback = fb; w.error_in = er; w.dt = dt; w.preset = pre;
        return w;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return $urandom();
            1: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [63:0] pick_limits();
        logic [31:0] a, b;
        a = $urandom_range(32'h0100_0000);
        b = -$urandom_range(32'h0100_0000);
        // Now and then the halves are written in the wrong order.
        return ($urandom_range(3) == 0) ? {b, a} : {a, b};
    endfunction

    task automatic random_setup();
        reg_write(REG_MODE, $urandom_range(31));
        reg_write(REG_KP, pick_gain());
        reg_write(REG_KI, pick_gain());
        reg_write(REG_KD, pick_gain());
        reg_write(REG_OLIM, pick_limits());
        reg_write(REG_DLIM, pick_limits());
        reg_write(REG_DBS, {32'($urandom_range(32'h0008_0000)) - 32'h0001_0000,
                            32'($urandom_range(32'h0000_4000)) - 32'h0000_1000});
        reg_write(REG_RAMP, ($urandom_range(1)) ? 64'd0 : 64'($urandom_range(32'h0100_0000)));
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        drain();
        random_setup();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_word(pick_word());
        stop_sending();
    endtask

    initial
    begin
        pred = new();
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_UPDATE;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: moderate gains first, then the registers at their extremes.
        reg_write(REG_MODE, 5'b00111);
        reg_write(REG_KP, 32'h0001_8000);
        reg_write(REG_KI, 32'h0000_8000);
        reg_write(REG_KD, 32'h0000_4000);
        reg_write(REG_OLIM, {32'h0064_0000, 32'hFF9C_0000});
        reg_write(REG_DLIM, {32'hFFF6_0000, 32'h000A_0000});  // swapped halves
        reg_write(REG_DBS, {32'h0020_0000, 32'h0000_0800});
        reg_write(REG_RAMP, 64'h0010_0000);
        // First update, then zero dt holds the output, then a ramped target.
        send_word(make_word(OP_UPDATE, 32'h0005_0000, 32'h0001_0000, 0, 24'h10_0000, 0));
        send_word(make_word(OP_UPDATE, 32'h0005_0000, 32'h0002_0000, 0, 24'd0, 0));
        send_word(make_word(OP_UPDATE, 32'h0050_0000, 32'h0002_0000, 0, 24'h01_0000, 0));
        send_word(make_word(OP_UPDATE, 32'h0050_0000, 32'h0003_0000, 0, 24'hFF_FFFF, 0));
        // Outside the deadband while the setpoint still ramps, then past the separation band.
        send_word(make_word(OP_UPDATE, 32'h0003_0400, 32'h0003_0000, 0, 24'h08_0000, 0));
        send_word(make_word(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 24'h08_0000, 0));
        // Error updates: the first feedback after one gets no derivative.
        send_word(make_word(OP_ERROR, 0, 0, 32'h8000_0000, 24'd1, 0));
        send_word(make_word(OP_ERROR, 0, 0, 32'h7FFF_FFFF, 24'h00_0001, 0));
        send_word(make_word(OP_ERROR, 0, 0, 32'h0001_0000, 24'd0, 0));
        send_word(make_word(OP_UPDATE, 32'h0001_0000, 32'h0000_8000, 0, 24'h04_0000, 0));
        send_word(make_word(OP_UPDATE, 32'h0001_0000, 32'hFFFF_0000, 0, 24'h04_0000, 0));
        // Resets, the output clamp applying to the loaded value.
        send_word(make_word(OP_RESET, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_word(make_word(OP_PRESET, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000));
        send_word(make_word(OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 24'hFF_FFFF, 0));
        stop_sending();
        drain();
        reg_write(REG_MODE, 5'b11111);
        reg_write(REG_KP, 32'h8000_0000);
        reg_write(REG_KI, 32'h7FFF_FFFF);
        reg_write(REG_KD, 32'h8000_0000);
        reg_write(REG_OLIM, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(REG_DLIM, 64'h8000_0000_7FFF_FFFF);
        reg_write(REG_DBS, 64'h7FFF_FFFF_8000_0000);
        reg_write(REG_RAMP, 64'h7FFF_FFFF);
        send_word(make_word(OP_PRESET, 32'h0001_0000, 0, 0, 0, 32'h0001_0000));
        send_word(make_word(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 24'd1, 0));
        send_word(make_word(OP_ERROR, 0, 0, 32'h8000_0000, 24'hFF_FFFF, 0));
        send_word(make_word(OP_ERROR, 0, 0, 32'h7FFF_FFFF, 24'd1, 0));
        send_word(make_word(OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 24'd1, 0));
        send_word(make_word(OP_RESET, 0, 0, 0, 0, 32'h8000_0000));
        stop_sending();
        drain();
        reg_write(REG_MODE, 5'b00000);
        reg_write(REG_OLIM, LIMIT_RESET);
        reg_write(REG_DLIM, LIMIT_RESET);
        reg_write(REG_DBS, 64'd0);
        reg_write(REG_RAMP, 64'd0);

        // Random part, idling by phase.
        run_phase(220, 0, 0);
        run_phase(220, 78, 0);
        run_phase(220, 0, 78);
        run_phase(220, 21, 21);

        // Back pressure: the receiver holds off while the sender keeps offering.
        drain();
        random_setup();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go <= 1'b1;
        repeat (20) send_word(pick_word());
        stop_sending();

        // The sender waits out every owed word between bursts.
        drain();
        repeat (10)
        begin
            repeat (5) send_word(pick_word());
            stop_sending();
            drain();
        end

        run_phase(220, 0, 0);
        run_phase(220, 78, 78);
        run_phase(220, 21, 21);
        run_phase(200, 0, 78);

        drain();
        if (pred.mismatches == 0 && pred.drive_expected.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* incremental_pid_controller_unit.f */
design/ipid_pkg.sv
design/ipid_mul.sv
design/ipid_div.sv
design/incremental_pid_controller_unit.sv
bench/tb_top.sv
